// ----- hw/rtl/mi3_pkg.sv -----
// ---------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse core
// Fixed output format, adjugate term table and divider depth.
// ---------------------------------------------------------------------------
package mi3_pkg;

	localparam int unsigned MATRIX_ORDER = 3;
	localparam int unsigned N_ELEM       = MATRIX_ORDER * MATRIX_ORDER;
	localparam int unsigned OUT_WIDTH    = 48;
	localparam int unsigned OUT_FRAC     = 32;
	// quotient bits kept: one above the output range for saturation
	localparam int unsigned DIV_STEPS    = OUT_WIDTH + 1;
	// precheck stage, one stage per quotient bit, saturation stage
	localparam int unsigned DIV_LAT      = DIV_STEPS + 2;

	// adjugate entry k = e[a]*e[b] - e[c]*e[d]
	localparam int unsigned ADJ_TERMS [N_ELEM][4] = '{
		'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
		'{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};

	typedef struct packed {
		logic                 sat;
		logic [OUT_WIDTH-1:0] value;
	} lane_out_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ----- hw/rtl/mi3_adj_lane.sv -----
// ---------------------------------------------------------------------------
// mi3_adj_lane: one adjugate entry
// Two element products in the first stage, their difference in the second.
// ---------------------------------------------------------------------------
module mi3_adj_lane #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	input  logic signed [W-1:0]   c,
	input  logic signed [W-1:0]   d,
	output logic signed [2*W:0]   adj
);

	localparam int PW = 2 * W;
	localparam int AW = 2 * W + 1;

	logic signed [PW-1:0] p_s1, q_s1;
	logic signed [AW-1:0] adj_s2;

	always_ff @(posedge clk) begin
		p_s1 <= PW'(a) * PW'(b);
		q_s1 <= PW'(c) * PW'(d);
	end

	always_ff @(posedge clk) begin
		adj_s2 <= AW'(p_s1) - AW'(q_s1);
	end

	assign adj = adj_s2;

endmodule

// ----- hw/rtl/mi3_det.sv -----
// ---------------------------------------------------------------------------
// mi3_det: determinant by cofactor expansion along row 0
// Each element times adjugate product is split into two partial products.
// ---------------------------------------------------------------------------
module mi3_det #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic signed [W-1:0] e0,
	input  logic signed [W-1:0] e1,
	input  logic signed [W-1:0] e2,
	input  logic signed [2*W:0] adj0,
	input  logic signed [2*W:0] adj1,
	input  logic signed [2*W:0] adj2,
	output logic signed [3*W+1:0] det
);

	localparam int AW = 2 * W + 1;
	localparam int PW = 2 * W + 1;
	localparam int DW = 3 * W + 2;

	logic signed [W-1:0]  e   [3];
	logic signed [AW-1:0] a   [3];
	logic signed [PW-1:0] plo_s1 [3];
	logic signed [PW-1:0] phi_s1 [3];
	logic signed [DW-1:0] term_s2 [3];
	logic signed [DW-1:0] det_s3;

	assign e[0] = e0;
	assign e[1] = e1;
	assign e[2] = e2;
	assign a[0] = adj0;
	assign a[1] = adj1;
	assign a[2] = adj2;

	for (genvar k = 0; k < 3; k++) begin : g_term
		logic signed [W:0] lo, hi;
		assign lo = $signed({1'b0, a[k][W-1:0]});
		assign hi = a[k][AW-1:W];

		always_ff @(posedge clk) begin
			plo_s1[k] <= PW'(e[k]) * PW'(lo);
			phi_s1[k] <= PW'(e[k]) * PW'(hi);
		end

		always_ff @(posedge clk) begin
			term_s2[k] <= (DW'(phi_s1[k]) <<< W) + DW'(plo_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		det_s3 <= term_s2[0] + term_s2[1] + term_s2[2];
	end

	assign det = det_s3;

endmodule

// ----- hw/rtl/mi3_div_lane.sv -----
// ---------------------------------------------------------------------------
// mi3_div_lane: pipelined restoring divider for one inverse element
// One quotient bit per stage, then saturation to the signed output range.
// ---------------------------------------------------------------------------
module mi3_div_lane #(
	parameter int NUM_W = 114,
	parameter int DEN_W = 98
) (
	input  logic               clk,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	input  logic               neg,
	output mi3_pkg::lane_out_t res
);

	localparam int STEPS = mi3_pkg::DIV_STEPS;
	localparam int OW    = mi3_pkg::OUT_WIDTH;
	localparam int XW    = mi3_pkg::max_int(NUM_W, DEN_W + STEPS);
	localparam int XW1   = XW + 1;

	logic [XW-1:0]    rem_q [STEPS+1];
	logic [STEPS-1:0] quo_q [STEPS+1];
	logic [DEN_W-1:0] den_q [STEPS+1];
	logic             neg_q [STEPS+1];
	logic             ovf_q [STEPS+1];
	mi3_pkg::lane_out_t res_q;

	// quotient would not fit in STEPS bits
	always_ff @(posedge clk) begin
		ovf_q[0] <= XW1'(num) >= (XW1'(den) << STEPS);
		rem_q[0] <= XW'(num);
		quo_q[0] <= '0;
		den_q[0] <= den;
		neg_q[0] <= neg;
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [XW-1:0] dsh;
		logic          ge;
		assign dsh = XW'(den_q[j]) << (STEPS - 1 - j);
		assign ge  = rem_q[j] >= dsh;

		always_ff @(posedge clk) begin
			rem_q[j+1] <= ge ? (rem_q[j] - dsh) : rem_q[j];
			quo_q[j+1] <= quo_q[j] | (STEPS'(ge) << (STEPS - 1 - j));
			den_q[j+1] <= den_q[j];
			neg_q[j+1] <= neg_q[j];
			ovf_q[j+1] <= ovf_q[j];
		end
	end

	logic [STEPS-1:0] qf;
	logic [OW-1:0]    pos_max, neg_lim, mag;
	logic             sat;

	assign qf      = quo_q[STEPS];
	assign pos_max = {1'b0, {(OW-1){1'b1}}};
	assign neg_lim = {1'b1, {(OW-1){1'b0}}};

	always_comb begin
		if (neg_q[STEPS]) begin
			sat = ovf_q[STEPS] || (qf > STEPS'(neg_lim));
			mag = sat ? neg_lim : qf[OW-1:0];
		end else begin
			sat = ovf_q[STEPS] || (qf > STEPS'(pos_max));
			mag = sat ? pos_max : qf[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		res_q.sat   <= sat;
		res_q.value <= neg_q[STEPS] ? (~mag + 1'b1) : mag;
	end

	assign res = res_q;

endmodule

// ----- hw/rtl/matrix3x3_inverse_core.sv -----
// ---------------------------------------------------------------------------
// matrix3x3_inverse_core: 3x3 matrix inverse by the adjugate
// Signed fixed-point elements in, signed Q16.32 inverse out, rounded to
// nearest with ties away from zero, saturated, with singular and overflow.
//
//  channel  signals                          transfer
//  input    start, busy, m00 .. m22          start high, busy low at clk
//  result   done, inv00 .. inv22, singular,  done high for one cycle
//           overflow
//
// one matrix can be taken every cycle; busy stays low
// a matrix passes the input register, products, adjugate, three
// determinant stages, operand setup, the nine divider lanes and the output
// register
// the divider lanes produce one quotient bit per stage
// reset clears only the result strobe pipeline
// results cannot be held off by the receiver
// ---------------------------------------------------------------------------
module matrix3x3_inverse_core #(
	parameter int ELEM_WIDTH     = 32,
	parameter int ELEM_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] m00,
	input  logic [31:0] m01,
	input  logic [31:0] m02,
	input  logic [31:0] m10,
	input  logic [31:0] m11,
	input  logic [31:0] m12,
	input  logic [31:0] m20,
	input  logic [31:0] m21,
	input  logic [31:0] m22,
	output logic        done,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv00,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv01,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv02,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv10,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv11,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv12,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv20,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv21,
	output logic signed [mi3_pkg::OUT_WIDTH-1:0] inv22,
	output logic        singular,
	output logic        overflow
);

	localparam int W     = ELEM_WIDTH;
	localparam int NE    = mi3_pkg::N_ELEM;
	localparam int AW    = 2 * W + 1;
	localparam int DW    = 3 * W + 2;
	localparam int SH    = ELEM_FRAC_BITS + mi3_pkg::OUT_FRAC + 1;
	localparam int NW    = mi3_pkg::max_int(2 * W + SH, DW - 1) + 1;
	localparam int LAT   = mi3_pkg::DIV_LAT;
	localparam int VLEN  = LAT + 8;
	localparam int OW    = mi3_pkg::OUT_WIDTH;

	logic [31:0]          m_in [NE];
	logic signed [W-1:0]  e_s1 [NE];
	logic signed [W-1:0]  e_s2 [3];
	logic signed [W-1:0]  e_s3 [3];
	logic signed [AW-1:0] adj_s3 [NE];
	logic signed [AW-1:0] adj_s4 [NE];
	logic signed [AW-1:0] adj_s5 [NE];
	logic signed [AW-1:0] adj_s6 [NE];
	logic signed [DW-1:0] det_s6;
	logic [NW-1:0]        num_s7 [NE];
	logic [DW-1:0]        den_s7;
	logic                 neg_s7 [NE];
	logic                 sing_s7;
	logic [LAT-1:0]       sing_dly_q;
	logic [VLEN-1:0]      vld_q;
	mi3_pkg::lane_out_t   lane_res [NE];
	logic [OW-1:0]        inv_q [NE];
	logic                 sing_q, ovf_q;

	assign m_in[0] = m00;
	assign m_in[1] = m01;
	assign m_in[2] = m02;
	assign m_in[3] = m10;
	assign m_in[4] = m11;
	assign m_in[5] = m12;
	assign m_in[6] = m20;
	assign m_in[7] = m21;
	assign m_in[8] = m22;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[VLEN-2:0], start & ~busy};
		end
	end

	// bits above the element width are dropped
	always_ff @(posedge clk) begin
		for (int k = 0; k < NE; k++) begin
			e_s1[k] <= m_in[k][W-1:0];
		end
	end

	for (genvar k = 0; k < NE; k++) begin : g_adj
		mi3_adj_lane #(.W(W)) u_adj (
			.clk (clk),
			.a   (e_s1[mi3_pkg::ADJ_TERMS[k][0]]),
			.b   (e_s1[mi3_pkg::ADJ_TERMS[k][1]]),
			.c   (e_s1[mi3_pkg::ADJ_TERMS[k][2]]),
			.d   (e_s1[mi3_pkg::ADJ_TERMS[k][3]]),
			.adj (adj_s3[k])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e_s2[k] <= e_s1[k];
			e_s3[k] <= e_s2[k];
		end
		for (int k = 0; k < NE; k++) begin
			adj_s4[k] <= adj_s3[k];
			adj_s5[k] <= adj_s4[k];
			adj_s6[k] <= adj_s5[k];
		end
	end

	mi3_det #(.W(W)) u_det (
		.clk  (clk),
		.e0   (e_s3[0]),
		.e1   (e_s3[1]),
		.e2   (e_s3[2]),
		.adj0 (adj_s3[0]),
		.adj1 (adj_s3[3]),
		.adj2 (adj_s3[6]),
		.det  (det_s6)
	);

	// operand setup: magnitudes, result signs, rounding offset
	logic          dneg;
	logic [DW-1:0] dabs;
	assign dneg = det_s6[DW-1];
	assign dabs = dneg ? DW'(-det_s6) : DW'(det_s6);

	always_ff @(posedge clk) begin
		sing_s7 <= (det_s6 == '0);
		den_s7  <= dabs << 1;
	end

	for (genvar k = 0; k < NE; k++) begin : g_prep
		logic [AW-1:0] aabs;
		assign aabs = adj_s6[k][AW-1] ? AW'(-adj_s6[k]) : AW'(adj_s6[k]);

		always_ff @(posedge clk) begin
			num_s7[k] <= (NW'(aabs[AW-2:0]) << SH) + NW'(dabs[DW-2:0]);
			neg_s7[k] <= adj_s6[k][AW-1] ^ dneg;
		end

		mi3_div_lane #(.NUM_W(NW), .DEN_W(DW)) u_div (
			.clk (clk),
			.num (num_s7[k]),
			.den (den_s7),
			.neg (neg_s7[k]),
			.res (lane_res[k])
		);
	end

	always_ff @(posedge clk) begin
		sing_dly_q <= {sing_dly_q[LAT-2:0], sing_s7};
	end

	// merge the lanes into one result
	logic any_sat;
	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < NE; k++) begin
			any_sat = any_sat | lane_res[k].sat;
		end
	end

	always_ff @(posedge clk) begin
		sing_q <= sing_dly_q[LAT-1];
		ovf_q  <= ~sing_dly_q[LAT-1] & any_sat;
		for (int k = 0; k < NE; k++) begin
			inv_q[k] <= sing_dly_q[LAT-1] ? '0 : lane_res[k].value;
		end
	end

	assign done     = vld_q[VLEN-1];
	assign singular = sing_q;
	assign overflow = ovf_q;
	assign inv00    = inv_q[0];
	assign inv01    = inv_q[1];
	assign inv02    = inv_q[2];
	assign inv10    = inv_q[3];
	assign inv11    = inv_q[4];
	assign inv12    = inv_q[5];
	assign inv20    = inv_q[6];
	assign inv21    = inv_q[7];
	assign inv22    = inv_q[8];

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb: testbench for matrix3x3_inverse_core
// Drives 3x3 Q16.16 matrices with random bursts and gaps, predicts each
// inverse by exact adjugate arithmetic and rounded division, and checks every
// result field in order against the queue of predicted inverses.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int LAT  = 8 + mi3_pkg::DIV_LAT;
	localparam int NE   = mi3_pkg::N_ELEM;
	localparam int OW   = mi3_pkg::OUT_WIDTH;

	typedef struct {
		logic [OW-1:0] inv [NE];
		logic          singular;
		logic          overflow;
	} inverse_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] m [NE];
	logic        done;
	logic signed [OW-1:0] inv [NE];
	logic        singular;
	logic        overflow;

	inverse_t inverse_q[$];
	int       errors;
	int       n_sent;
	int       n_checked;
	int       n_singular;
	int       n_overflow;

	matrix3x3_inverse_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]),
		.m12(m[5]), .m20(m[6]), .m21(m[7]), .m22(m[8]), .done(done),
		.inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]),
		.inv11(inv[4]), .inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]),
		.inv22(inv[8]), .singular(singular), .overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	// exact adjugate and determinant, then round(|adj| * 2^48 / |det|)
	function automatic inverse_t predict_inverse(input logic [31:0] mat [NE]);
		inverse_t r;
		logic signed [127:0] e [NE];
		logic signed [127:0] adj [NE];
		logic signed [127:0] det;
		logic [127:0] amag, dmag, q;
		logic [OW-1:0] pmax;
		logic neg;
		pmax = {1'b0, {(OW-1){1'b1}}};
		for (int k = 0; k < NE; k++)
			e[k] = 128'(signed'(mat[k]));
		adj[0] = e[4]*e[8] - e[7]*e[5]; adj[1] = e[2]*e[7] - e[1]*e[8];
		adj[2] = e[1]*e[5] - e[2]*e[4]; adj[3] = e[5]*e[6] - e[3]*e[8];
		adj[4] = e[0]*e[8] - e[2]*e[6]; adj[5] = e[3]*e[2] - e[0]*e[5];
		adj[6] = e[3]*e[7] - e[6]*e[4]; adj[7] = e[6]*e[1] - e[0]*e[7];
		adj[8] = e[0]*e[4] - e[3]*e[1];
		det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
		r.overflow = 1'b0;
		r.singular = (det == 0);
		for (int k = 0; k < NE; k++)
			r.inv[k] = '0;
		if (r.singular)
			return r;
		dmag = det < 0 ? -det : det;
		for (int k = 0; k < NE; k++) begin
			neg  = (adj[k] < 0) != (det < 0);
			amag = adj[k] < 0 ? -adj[k] : adj[k];
			q = ((amag << (FRAC + mi3_pkg::OUT_FRAC + 1)) + dmag) / (dmag << 1);
			if (neg) begin
				if (q > 128'(pmax) + 1) begin
					r.overflow = 1'b1;
					q = 128'(pmax) + 1;
				end
				r.inv[k] = OW'(-q);
			end else begin
				if (q > 128'(pmax)) begin
					r.overflow = 1'b1;
					q = 128'(pmax);
				end
				r.inv[k] = OW'(q);
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (inverse_q.size() == 0) begin
				$display("%t: result with no matrix pending: inv00=%h", $realtime, inv[0]);
				errors++;
			end else begin
				inverse_t x;
				x = inverse_q.pop_front();
				for (int k = 0; k < NE; k++)
					if (inv[k] !== x.inv[k]) begin
						$display("%t: inv[%0d] expected %h actual %h", $realtime, k,
							x.inv[k], inv[k]);
						errors++;
					end
				if (singular !== x.singular) begin
					$display("%t: singular expected %b actual %b", $realtime,
						x.singular, singular);
					errors++;
				end
				if (overflow !== x.overflow) begin
					$display("%t: overflow expected %b actual %b", $realtime,
						x.overflow, overflow);
					errors++;
				end
				n_checked++;
				n_singular += x.singular;
				n_overflow += x.overflow;
			end
		end
	end

	int gap_left;
	int burst_left;

	// one transfer, with a random gap pattern in bursts
	task automatic send_matrix(input logic [31:0] mat [NE]);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		if (gap_left > 0) begin
			start <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		start <= 1'b1;
		for (int k = 0; k < NE; k++)
			m[k] <= mat[k];
		do
			@(posedge clk);
		while (busy);
		inverse_q.push_back(predict_inverse(mat));
		n_sent++;
		burst_left--;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (inverse_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			3: return 32'(signed'($urandom_range(0, 16)) - 8);
			default: return 32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] a [NE];
		logic [31:0] one;
		one = 32'h0001_0000;
		a = '{one, 0, 0, 0, one, 0, 0, 0, one};                         send_matrix(a);
		a = '{-one, 0, 0, 0, 2*one, 0, 0, 0, one/2};                    send_matrix(a);
		a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                                send_matrix(a);
		a = '{one, 2*one, 3*one, 2*one, 4*one, 6*one, one, one, one};   send_matrix(a);
		a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                                send_matrix(a);
		a = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};                              send_matrix(a);
		a = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff}; send_matrix(a);
		a = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000}; send_matrix(a);
		a = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
		send_matrix(a);
		a = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}; send_matrix(a);
		a = '{3*one, 0, 0, 0, 3*one, 0, 0, 0, 3*one};                   send_matrix(a);
		a = '{2, 1, 0, 1, 2, 1, 0, 1, 2};                                send_matrix(a);
		a = '{0, one, 0, one, 0, 0, 0, 0, one};                          send_matrix(a);
		// exact -2^47 lane: 1/x = -32768 needs x = -2 raw units (-2^-15)
		a = '{-2, 0, 0, 0, one, 0, 0, 0, one};                           send_matrix(a);
		a = '{2, 0, 0, 0, one, 0, 0, 0, one};                            send_matrix(a);
		drain();
	endtask

	task automatic test_random();
		logic [31:0] a [NE];
		for (int i = 0; i < 1400; i++) begin
			for (int k = 0; k < NE; k++)
				a[k] = rand_elem();
			// some rank-deficient matrices: copy or zero a row
			if ($urandom_range(0, 15) == 0)
				for (int k = 0; k < 3; k++)
					a[6+k] = a[3+k];
			else if ($urandom_range(0, 31) == 0)
				for (int k = 0; k < 3; k++)
					a[k] = '0;
			send_matrix(a);
			if (i == 700)
				drain();
		end
		drain();
	endtask

	initial begin
		errors = 0; n_sent = 0; n_checked = 0; n_singular = 0; n_overflow = 0;
		gap_left = 0; burst_left = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		for (int k = 0; k < NE; k++)
			m[k] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		repeat (LAT + 10) @(posedge clk);
		$display("sent %0d matrices, checked %0d inverses", n_sent, n_checked);
		$display("%0d singular, %0d saturated", n_singular, n_overflow);
		if (errors == 0 && inverse_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_adj_lane.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div_lane.sv
hw/rtl/matrix3x3_inverse_core.sv
tb/tb.sv
